// ----- hw/rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants of the I2C master bit sequencer
// Command codes, queue sizing and the item that travels from front to back.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes carried in in_tuser
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_ACK   = 3'd3;
  localparam logic [2:0] CMD_NACK  = 3'd4;
  localparam logic [2:0] CMD_WAIT  = 3'd5;
  localparam logic [2:0] CMD_WRITE = 3'd6;
  localparam logic [2:0] CMD_READ  = 3'd7;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_POLL_LIMIT  = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [7:0]  POLL_LIMIT_RST  = 8'd200;

  // tick queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic       has_cmd;
    logic [2:0] cmd;
    logic [7:0] wdata;
    logic       ack_bit;
    logic       sda;
  } tick_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hw/rtl/i2cms_front.sv -----
// ----------------------------------------------------------------------------
// i2cms_front: tick intake
// Accepts one tick transfer, unpacks and classifies it for the queue.
// ----------------------------------------------------------------------------
module i2cms_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic [2:0]            in_tuser,
  input  i2cms_pkg::q_status_t  q_stat,
  output logic                  push,
  output i2cms_pkg::tick_item_t push_item
);
  import i2cms_pkg::*;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  always_comb begin
    push_item.has_cmd = (in_tuser != CMD_NONE);
    push_item.cmd     = in_tuser;
    push_item.wdata   = in_tdata[7:0];
    push_item.ack_bit = in_tdata[8];
    push_item.sda     = in_tdata[9];
  end

endmodule

// ----- hw/rtl/i2cms_queue.sv -----
// ----------------------------------------------------------------------------
// i2cms_queue: short tick queue
// Flop-based FIFO that lets intake and sequencer stall independently.
// ----------------------------------------------------------------------------
module i2cms_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cms_pkg::tick_item_t push_item,
  input  logic                  pop,
  output i2cms_pkg::tick_item_t pop_item,
  output i2cms_pkg::q_status_t  q_stat
);
  import i2cms_pkg::*;

  tick_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/i2cms_back.sv -----
// ----------------------------------------------------------------------------
// i2cms_back: bus level sequencer
// Plays one tick per cycle on the SCL/SDA phase machine while the output register
// can take it; holds config registers and the output register.
// ----------------------------------------------------------------------------
module i2cms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  i2cms_pkg::q_status_t  q_stat,
  input  i2cms_pkg::tick_item_t pop_item,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata
);
  import i2cms_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_PRE  = 4'd1;
  localparam logic [3:0] PH_ST_HI   = 4'd2;
  localparam logic [3:0] PH_ST_LOW  = 4'd3;
  localparam logic [3:0] PH_SP_A    = 4'd4;
  localparam logic [3:0] PH_SP_B    = 4'd5;
  localparam logic [3:0] PH_SP_C    = 4'd6;
  localparam logic [3:0] PH_AK_LO   = 4'd7;
  localparam logic [3:0] PH_AK_HI   = 4'd8;
  localparam logic [3:0] PH_WB_LO   = 4'd9;
  localparam logic [3:0] PH_WB_HI   = 4'd10;
  localparam logic [3:0] PH_WA_LO   = 4'd11;
  localparam logic [3:0] PH_WA_HI   = 4'd12;
  localparam logic [3:0] PH_WA_POLL = 4'd13;
  localparam logic [3:0] PH_RB_LO   = 4'd14;
  localparam logic [3:0] PH_RB_HI   = 4'd15;

  // {scl, sda} driven while a phase is held
  function automatic logic [1:0] phase_levels(input logic [3:0] ph, input logic ackb,
                                              input logic msb);
    logic [1:0] lv;
    begin
      lv = 2'b01;
      case (ph)
        PH_ST_PRE:  lv = 2'b01;
        PH_ST_HI:   lv = 2'b11;
        PH_ST_LOW:  lv = 2'b10;
        PH_SP_A:    lv = 2'b00;
        PH_SP_B:    lv = 2'b10;
        PH_SP_C:    lv = 2'b11;
        PH_AK_LO:   lv = {1'b0, ackb};
        PH_AK_HI:   lv = {1'b1, ackb};
        PH_WB_LO:   lv = {1'b0, msb};
        PH_WB_HI:   lv = {1'b1, msb};
        PH_WA_LO:   lv = 2'b01;
        PH_WA_HI:   lv = 2'b11;
        PH_WA_POLL: lv = 2'b11;
        PH_RB_LO:   lv = 2'b01;
        PH_RB_HI:   lv = 2'b11;
        default:    lv = 2'b01;
      endcase
      return lv;
    end
  endfunction

  logic [15:0] half_r;
  logic [7:0]  limit_r;

  logic [3:0]  phase_r,  phase_nxt;
  logic [2:0]  cmd_r,    cmd_nxt;
  logic [3:0]  bit_r,    bit_nxt;
  logic [7:0]  shift_r,  shift_nxt;
  logic [15:0] timer_r,  timer_nxt;
  logic [7:0]  poll_r,   poll_nxt;
  logic        pack_r,   pack_nxt;
  logic        scl_r,    scl_nxt;
  logic        sda_r,    sda_nxt;
  logic [7:0]  rhold_r,  rhold_nxt;
  logic        nack_r,   nack_nxt;
  logic        done_nxt;
  logic        out_vld_r;
  logic [15:0] out_dat_r, out_dat_nxt;

  logic        go;
  logic        fin;
  logic [3:0]  tgt;
  logic        expire;
  logic [15:0] half_eff;
  logic [1:0]  lv;

  assign pop        = !q_stat.empty && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign half_eff   = (half_r == '0) ? 16'd1 : half_r;
  assign expire     = (timer_r <= 16'd1);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    timer_nxt = timer_r;
    poll_nxt  = poll_r;
    pack_nxt  = pack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rhold_nxt = rhold_r;
    nack_nxt  = nack_r;
    done_nxt  = 1'b0;
    go        = 1'b0;
    fin       = 1'b0;
    tgt       = PH_IDLE;
    lv        = 2'b11;

    if (phase_r == PH_IDLE) begin
      if (pop_item.has_cmd) begin
        cmd_nxt = pop_item.cmd;
        go      = 1'b1;
        case (pop_item.cmd)
          CMD_START: tgt = PH_ST_PRE;
          CMD_STOP:  tgt = PH_SP_A;
          CMD_ACK: begin
            pack_nxt = 1'b0;
            tgt      = PH_AK_LO;
          end
          CMD_NACK: begin
            pack_nxt = 1'b1;
            tgt      = PH_AK_LO;
          end
          CMD_WAIT: begin
            poll_nxt = '0;
            tgt      = PH_WA_LO;
          end
          CMD_WRITE: begin
            shift_nxt = pop_item.wdata;
            bit_nxt   = '0;
            tgt       = PH_WB_LO;
          end
          default: begin
            shift_nxt = '0;
            bit_nxt   = '0;
            pack_nxt  = pop_item.ack_bit;
            tgt       = PH_RB_LO;
          end
        endcase
      end
    end else if (phase_r == PH_WA_POLL) begin
      if (!pop_item.sda) begin
        nack_nxt = 1'b0;
        fin      = 1'b1;
      end else if (poll_r >= limit_r) begin
        nack_nxt = 1'b1;
        go       = 1'b1;
        tgt      = PH_SP_A;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else if (expire) begin
      case (phase_r)
        PH_ST_PRE: begin go = 1'b1; tgt = PH_ST_HI; end
        PH_ST_HI:  begin go = 1'b1; tgt = PH_ST_LOW; end
        PH_SP_A:   begin go = 1'b1; tgt = PH_SP_B; end
        PH_SP_B:   begin go = 1'b1; tgt = PH_SP_C; end
        PH_AK_LO:  begin go = 1'b1; tgt = PH_AK_HI; end
        PH_AK_HI: begin
          if (cmd_r == CMD_READ) begin
            rhold_nxt = shift_r;
          end
          fin = 1'b1;
        end
        PH_WB_LO:  begin go = 1'b1; tgt = PH_WB_HI; end
        PH_WB_HI: begin
          bit_nxt = bit_r + 4'd1;
          if (bit_nxt >= 4'd8) begin
            fin = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            go        = 1'b1;
            tgt       = PH_WB_LO;
          end
        end
        PH_WA_LO:  begin go = 1'b1; tgt = PH_WA_HI; end
        PH_WA_HI:  begin go = 1'b1; tgt = PH_WA_POLL; end
        PH_RB_LO:  begin go = 1'b1; tgt = PH_RB_HI; end
        PH_RB_HI: begin
          // sample SDA at the last tick of SCL high
          shift_nxt = {shift_r[6:0], pop_item.sda};
          bit_nxt   = bit_r + 4'd1;
          go        = 1'b1;
          tgt       = (bit_nxt >= 4'd8) ? PH_AK_LO : PH_RB_LO;
        end
        default: fin = 1'b1;  // start low level and stop high level end here
      endcase
    end else begin
      timer_nxt = timer_r - 16'd1;
    end

    if (go) begin
      lv        = phase_levels(tgt, pack_nxt, shift_nxt[7]);
      phase_nxt = tgt;
      scl_nxt   = lv[1];
      sda_nxt   = lv[0];
      timer_nxt = half_eff;
    end
    if (fin) begin
      if (phase_r != PH_SP_C) begin
        scl_nxt = 1'b0;
      end
      phase_nxt = PH_IDLE;
      timer_nxt = '0;
      done_nxt  = 1'b1;
    end

    out_dat_nxt = {3'b000, nack_nxt, rhold_nxt, done_nxt, (phase_nxt != PH_IDLE),
                   sda_nxt, scl_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_PERIOD_RST;
      limit_r   <= POLL_LIMIT_RST;
      phase_r   <= PH_IDLE;
      cmd_r     <= CMD_NONE;
      bit_r     <= '0;
      shift_r   <= '0;
      timer_r   <= '0;
      poll_r    <= '0;
      pack_r    <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rhold_r   <= '0;
      nack_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HALF_PERIOD: half_r  <= cfg_wdata;
          CFG_POLL_LIMIT:  limit_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (pop) begin
        phase_r <= phase_nxt;
        cmd_r   <= cmd_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        timer_r <= timer_nxt;
        poll_r  <= poll_nxt;
        pack_r  <= pack_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        rhold_r <= rhold_nxt;
        nack_r  <= nack_nxt;
      end
      if (pop) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_dat_r <= out_dat_nxt;
    end
  end

endmodule

// ----- hw/rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer: I2C master bit-level controller, one tick per item
// An accepted tick is registered in the queue, then in the output register when popped.
// One tick per cycle while the queue is not empty and out_tready does not stall output.
// The 4-entry tick queue keeps intake running while a result waits on out_tready.
// Reset (rst_n low, synchronous): queue and output emptied, bus released (1,1),
// half period 5 ticks, poll limit 200, held read byte and NACK flag cleared.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes: index 0 half_period_ticks, 1 ack_poll_limit
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // tick input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] ack_to_send, [9] sda_in
  input  logic [2:0]  in_tuser,   // [2:0] command
  // tick results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] scl_out, [1] sda_out, [2] busy_res,
                                  // [3] done_res, [11:4] read_value, [12] nack_seen
);
  import i2cms_pkg::*;

  // front -> queue -> back. The front only classifies; every tick, with or
  // without a command, is a transfer through the queue since each one
  // advances the bus timing by one tick.
  logic       push;
  logic       pop;
  tick_item_t push_item;
  tick_item_t pop_item;
  q_status_t  q_stat;

  i2cms_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  i2cms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // back end: one tick per cycle whenever the output register can take it;
  // SCL/SDA level timing counts ticks, not clocks
  i2cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/i2cms_checker.sv -----
// ----------------------------------------------------------------------------
// i2cms_checker: port-level checks for the I2C master bit sequencer
// Watches the result stream; bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // finishing tick reports idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done with busy set");

  // a finished command leaves SCL low, unless it ended on a stop (1,1)
  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[0] || out_tdata[1])
    else $error("bad bus levels at command end");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:13] == 3'b000)
    else $error("nonzero pad bits in result");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
